FILE: rtl/core/miller_rabin_prime_test_top_macros.svh
// assertion macros for the miller-rabin prime test block
// used by the core modules, no other dependencies
`ifndef MILLER_RABIN_PRIME_TEST_TOP_MACROS_SVH
`define MILLER_RABIN_PRIME_TEST_TOP_MACROS_SVH

// implication checked every clock outside reset
`define MR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication checked outside reset
`define MR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/core/mrpt_pkg.sv
// package for the miller-rabin prime test block
// holds sizes and the small prime table, no dependencies
`default_nettype none
package mrpt_pkg;
    localparam int NUM_WIDTH_DEF    = 64;
    localparam int NUM_BASES_DEF    = 12;
    localparam int NUM_SMALL_PRIMES = 12;
    localparam int PIDX_W           = 4;
    localparam int PVAL_W           = 6;

    // the first twelve primes, index 0 to 11
    function automatic logic [PVAL_W-1:0] small_prime(input logic [PIDX_W-1:0] idx);
        logic [PVAL_W-1:0] v;
        case (idx)
            4'd0:  v = 6'd2;
            4'd1:  v = 6'd3;
            4'd2:  v = 6'd5;
            4'd3:  v = 6'd7;
            4'd4:  v = 6'd11;
            4'd5:  v = 6'd13;
            4'd6:  v = 6'd17;
            4'd7:  v = 6'd19;
            4'd8:  v = 6'd23;
            4'd9:  v = 6'd29;
            4'd10: v = 6'd31;
            4'd11: v = 6'd37;
            default: v = 6'd2;
        endcase
        return v;
    endfunction

    // request to the shift-add modular multiplier
    typedef struct packed {
        logic start;
    } t_mul_ctl;
endpackage
`default_nettype wire

FILE: rtl/core/mrpt_modmul.sv
// bit-serial shift-add modular multiplier, one multiplier bit per cycle
// depends on mrpt_pkg
`default_nettype none
module mrpt_modmul
    import mrpt_pkg::*;
#(
    parameter int W = NUM_WIDTH_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire t_mul_ctl     i_ctl,
    input  wire logic [W-1:0] i_x,
    input  wire logic [W-1:0] i_y,
    input  wire logic [W-1:0] i_m,
    output logic              o_busy,
    output logic              o_done,
    output logic [W-1:0]      o_p
);
    logic [W-1:0] r_acc, n_acc;
    logic [W-1:0] r_a, n_a;
    logic [W-1:0] r_y, n_y;
    logic         r_busy, n_busy;
    logic         r_done, n_done;
    logic [W:0]   s_add, s_dbl;

    // add with a carry bit, reduce once; operands are below m
    always_comb begin
        s_add = {1'b0, r_acc} + {1'b0, r_a};
        s_dbl = {1'b0, r_a} + {1'b0, r_a};
        n_acc = r_acc;
        n_a   = r_a;
        n_y   = r_y;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_ctl.start) begin
            n_acc  = '0;
            n_a    = i_x;
            n_y    = i_y;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_y == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                if (r_y[0])
                    n_acc = (s_add >= {1'b0, i_m}) ? W'(s_add - {1'b0, i_m}) : W'(s_add);
                n_a = (s_dbl >= {1'b0, i_m}) ? W'(s_dbl - {1'b0, i_m}) : W'(s_dbl);
                n_y = r_y >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_acc <= n_acc;
        r_a   <= n_a;
        r_y   <= n_y;
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_p    = r_acc;

`include "miller_rabin_prime_test_top_macros.svh"
    `MR_ASSERT_IMP(a_done_not_busy, i_clk, i_rst_n, r_done, !r_busy)
    `MR_ASSERT_NXT(a_start_busy, i_clk, i_rst_n, i_ctl.start, r_busy)
    `MR_ASSERT_IMP(a_acc_below_m, i_clk, i_rst_n, r_done && (i_m > W'(1)), r_acc < i_m)
endmodule
`default_nettype wire

FILE: rtl/core/mrpt_rem.sv
// bit-serial remainder of the candidate by a small constant, msb first
// depends on mrpt_pkg
`default_nettype none
module mrpt_rem
    import mrpt_pkg::*;
#(
    parameter int W = NUM_WIDTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [W-1:0]      i_n,
    input  wire logic [PVAL_W-1:0] i_p,
    output logic                   o_done,
    output logic                   o_zero
);
    localparam int CW = $clog2(W + 1);
    logic [W-1:0]      r_sh;
    logic [PVAL_W-1:0] r_rem;
    logic [CW-1:0]     r_cnt;
    logic              r_busy, r_done;
    logic [PVAL_W:0]   s_t;

    // shift one bit into the remainder each cycle while busy
    assign s_t = {r_rem, r_sh[W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CW'(W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
        if (i_start) begin
            r_sh  <= i_n;
            r_rem <= '0;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_sh  <= r_sh << 1;
            r_rem <= (s_t >= {1'b0, i_p}) ? PVAL_W'(s_t - {1'b0, i_p}) : PVAL_W'(s_t);
            r_cnt <= r_cnt + CW'(1);
        end
    end

    assign o_done = r_done;
    assign o_zero = (r_rem == '0);
endmodule
`default_nettype wire

FILE: rtl/core/miller_rabin_prime_test_top.sv
// miller-rabin prime test: one candidate in, one prime flag out
// trial division by each small prime, then per base a square-and-multiply
// exponentiation and a squaring loop on the shift-add multiplier, which
// works one bit a cycle
// one item at a time; reset (synchronous, low) clears control and drops any result
`default_nettype none
module miller_rabin_prime_test_top
    import mrpt_pkg::*;
#(
    parameter int NUM_WIDTH = NUM_WIDTH_DEF,
    parameter int NUM_BASES = NUM_BASES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // tdata: candidate[63:0]
    input  wire logic [63:0] s_axis_tdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata: is_prime[0], zero fill [7:1]
    output logic [7:0]       m_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready
);
    localparam int W  = NUM_WIDTH;
    localparam int RW = $clog2(W);

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_TDIV  = 10'b0000000010,
        ST_TWAIT = 10'b0000000100,
        ST_SPLIT = 10'b0000001000,
        ST_BASE  = 10'b0000010000,
        ST_EXP   = 10'b0000100000,
        ST_EWAIT = 10'b0001000000,
        ST_CHK   = 10'b0010000000,
        ST_SQW   = 10'b0100000000,
        ST_OUT   = 10'b1000000000
    } t_state;

    t_state            r_st;
    logic [W-1:0]      r_n, r_d, r_e, r_x, r_b;
    logic [RW-1:0]     r_r, r_i;
    logic [PIDX_W-1:0] r_pi;
    logic              r_res;
    logic              r_phase;   // 0: acc*b, 1: b*b
    logic              r_sq;      // squaring loop of the witness
    logic              r_tstart;
    t_mul_ctl          r_mctl;
    logic [W-1:0]      r_mx, r_my;
    logic              m_busy, m_done, t_done, t_zero;
    logic [W-1:0]      m_p;
    logic [W-1:0]      nm1;
    logic [PVAL_W-1:0] cur_p;
    logic              chk_pass;
    logic              n_tstart, n_mstart;

    assign nm1   = r_n - W'(1);
    assign cur_p = small_prime(r_pi);

    // start pulses for the remainder and multiplier units
    always_comb begin
        chk_pass = (!r_sq && r_x == W'(1)) || r_x == nm1;
        n_tstart = (r_st == ST_TDIV) && (r_n != W'(cur_p));
        n_mstart = ((r_st == ST_EXP) && (r_e != '0))
                || ((r_st == ST_EWAIT) && m_done && !r_phase)
                || ((r_st == ST_CHK) && !chk_pass && (r_i < r_r));
    end

    mrpt_modmul #(.W(W)) u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(r_mctl),
        .i_x(r_mx), .i_y(r_my), .i_m(r_n),
        .o_busy(m_busy), .o_done(m_done), .o_p(m_p)
    );

    mrpt_rem #(.W(W)) u_rem (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_tstart),
        .i_n(r_n), .i_p(cur_p), .o_done(t_done), .o_zero(t_zero)
    );

    assign s_axis_tready = (r_st == ST_IDLE);
    assign m_axis_tvalid = (r_st == ST_OUT);
    assign m_axis_tdata  = {7'd0, r_res};

    // main sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st         <= ST_IDLE;
            r_tstart     <= 1'b0;
            r_mctl.start <= 1'b0;
        end else begin
            r_tstart     <= n_tstart;
            r_mctl.start <= n_mstart;
            unique case (r_st)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_n  <= W'(s_axis_tdata);
                        r_pi <= '0;
                        if (W'(s_axis_tdata) < W'(2)) begin
                            r_res <= 1'b0;
                            r_st  <= ST_OUT;
                        end else begin
                            r_st <= ST_TDIV;
                        end
                    end
                end
                ST_TDIV: begin
                    if (r_n == W'(cur_p)) begin
                        r_res <= 1'b1;
                        r_st  <= ST_OUT;
                    end else begin
                        r_st <= ST_TWAIT;
                    end
                end
                ST_TWAIT: begin
                    if (t_done) begin
                        if (t_zero) begin
                            r_res <= 1'b0;
                            r_st  <= ST_OUT;
                        end else if (r_pi == PIDX_W'(NUM_SMALL_PRIMES - 1)) begin
                            r_d  <= r_n - W'(1);
                            r_r  <= '0;
                            r_pi <= '0;
                            r_st <= ST_SPLIT;
                        end else begin
                            r_pi <= r_pi + PIDX_W'(1);
                            r_st <= ST_TDIV;
                        end
                    end
                end
                // strip trailing zeros one a cycle
                ST_SPLIT: begin
                    if (r_d[0] || r_d == '0) begin
                        r_st <= ST_BASE;
                    end else begin
                        r_d <= r_d >> 1;
                        r_r <= r_r + RW'(1);
                    end
                end
                ST_BASE: begin
                    if (r_pi == PIDX_W'(NUM_BASES)) begin
                        r_res <= 1'b1;
                        r_st  <= ST_OUT;
                    end else begin
                        r_x     <= W'(1);
                        r_b     <= W'(cur_p);  // n > 37, so base < n
                        r_e     <= r_d;
                        r_sq    <= 1'b0;
                        r_st    <= ST_EXP;
                    end
                end
                // one exponent bit: optional acc*b, then b*b
                ST_EXP: begin
                    if (r_e == '0) begin
                        r_i  <= RW'(1);
                        r_st <= ST_CHK;
                    end else if (r_e[0]) begin
                        r_mx <= r_x; r_my <= r_b;
                        r_phase <= 1'b0;
                        r_st <= ST_EWAIT;
                    end else begin
                        r_mx <= r_b; r_my <= r_b;
                        r_phase <= 1'b1;
                        r_st <= ST_EWAIT;
                    end
                end
                ST_EWAIT: begin
                    if (m_done) begin
                        if (!r_phase) begin
                            r_x  <= m_p;
                            r_mx <= r_b; r_my <= r_b;
                            r_phase <= 1'b1;
                        end else begin
                            r_b  <= m_p;
                            r_e  <= r_e >> 1;
                            r_st <= ST_EXP;
                        end
                    end
                end
                ST_CHK: begin
                    if (chk_pass) begin
                        r_pi <= r_pi + PIDX_W'(1);
                        r_st <= ST_BASE;
                    end else if (r_i >= r_r) begin
                        r_res <= 1'b0;
                        r_st  <= ST_OUT;
                    end else begin
                        r_mx <= r_x; r_my <= r_x;
                        r_sq <= 1'b1;
                        r_st <= ST_SQW;
                    end
                end
                ST_SQW: begin
                    if (m_done) begin
                        r_x  <= m_p;
                        r_i  <= r_i + RW'(1);
                        r_st <= ST_CHK;
                    end
                end
                ST_OUT: begin
                    if (m_axis_tready)
                        r_st <= ST_IDLE;
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

`include "miller_rabin_prime_test_top_macros.svh"
    `MR_ASSERT_IMP(a_mul_idle_out, i_clk, i_rst_n, r_st == ST_OUT, !m_busy)
    `MR_ASSERT_IMP(a_ready_idle, i_clk, i_rst_n, s_axis_tready, !m_axis_tvalid)
    `MR_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata))
endmodule
`default_nettype wire
